/* rtl/ook_pulse_width_code_decoder_assert.svh */
// assertion macros shared by the decoder modules
`ifndef OOK_PULSE_WIDTH_CODE_DECODER_ASSERT_SVH
`define OOK_PULSE_WIDTH_CODE_DECODER_ASSERT_SVH

// consequent checked in the same cycle
`define OOKPW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define OOKPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ookpw_pkg.sv */
// shared types and constants for the pulse width code decoder
`timescale 1ns / 1ps

package ookpw_pkg;

	localparam int ALPHA_W = 15;
	localparam int COUNT_W = 6;
	localparam int CODE_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int APB_W   = 32;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = 15'd350;
	localparam logic [COUNT_W-1:0] COUNT_RST = 6'd24;

	typedef enum logic [0:0] {
		REG_ALPHA_US  = 1'b0,
		REG_BIT_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha_us;
		logic [COUNT_W-1:0] bit_count;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
		logic              ok;
	} result_t;

endpackage

/* rtl/ookpw_cfg.sv */
// configuration registers behind the apb port
`timescale 1ns / 1ps

module ookpw_cfg import ookpw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	// registers sit on word addresses, byte lanes ignored
	assign idx    = reg_idx_t'(paddr[2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_us  <= ALPHA_RST;
			cfg_q.bit_count <= COUNT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ALPHA_US: begin
					cfg_q.alpha_us <= pwdata[ALPHA_W-1:0];
				end
				REG_BIT_COUNT: begin
					cfg_q.bit_count <= pwdata[COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ALPHA_US: begin
				prdata = APB_W'(cfg_q.alpha_us);
			end
			REG_BIT_COUNT: begin
				prdata = APB_W'(cfg_q.bit_count);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

/* rtl/ookpw_core.sv */
// frame alignment, pair classification and code shift register
`timescale 1ns / 1ps

module ookpw_core import ookpw_pkg::*; #(
	parameter int MAX_BITS      = 32,
	parameter int DURATION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     take,
	input  logic [DURATION_BITS-1:0] duration,
	input  logic                     first_level,
	input  logic                     last_of_capture,
	output result_t                  result
);

	typedef enum logic [2:0] {
		POS_START  = 3'd0,
		POS_SECOND = 3'd1,
		POS_SKIP   = 3'd2,
		POS_ON     = 3'd3,
		POS_OFF    = 3'd4
	} pos_t;

	typedef enum logic [1:0] {
		OUT_RUNNING = 2'd0,
		OUT_FAILED  = 2'd1,
		OUT_DONE    = 2'd2
	} outcome_t;

	pos_t                     pos_q, pos_d;
	outcome_t                 outcome_q, outcome_d;
	logic [DURATION_BITS-1:0] held_q, held_d;
	logic                     level_q, level_d;
	logic [MAX_BITS-1:0]      shift_q, shift_d;
	logic [COUNT_W-1:0]       bits_q, bits_d;

	logic [DURATION_BITS-1:0] split, sync;
	logic                     count_ok;
	logic                     dur_sync, dur_long, on_sync, on_long;
	logic                     do_pair;

	assign split    = DURATION_BITS'({cfg.alpha_us, 1'b0});
	assign sync     = DURATION_BITS'({cfg.alpha_us, 4'b0});
	assign count_ok = (cfg.bit_count != '0) && (cfg.bit_count <= COUNT_W'(MAX_BITS));
	assign dur_sync = duration >= sync;
	assign dur_long = duration >= split;
	// the held duration is always the on half of a pair
	assign on_sync  = held_q >= sync;
	assign on_long  = held_q >= split;

	always_comb begin
		pos_d     = pos_q;
		held_d    = held_q;
		level_d   = level_q;
		shift_d   = shift_q;
		bits_d    = bits_q;
		outcome_d = outcome_q;
		do_pair   = 1'b0;
		case (pos_q)
			POS_START: begin
				held_d  = duration;
				level_d = first_level;
				pos_d   = POS_SECOND;
			end
			POS_SECOND: begin
				if (dur_sync) begin
					// sync pair, skip one more item if the capture began with a gap
					pos_d = level_q ? POS_ON : POS_SKIP;
				end else if (level_q) begin
					do_pair = 1'b1;
					pos_d   = POS_ON;
				end else begin
					held_d = duration;
					pos_d  = POS_OFF;
				end
			end
			POS_SKIP: begin
				pos_d = POS_ON;
			end
			POS_ON: begin
				held_d = duration;
				pos_d  = POS_OFF;
			end
			POS_OFF: begin
				do_pair = 1'b1;
				pos_d   = POS_ON;
			end
			default: begin
				pos_d = POS_START;
			end
		endcase

		if (do_pair && outcome_q == OUT_RUNNING) begin
			if (!count_ok || on_sync || dur_sync) begin
				outcome_d = OUT_FAILED;
			end else if (on_long == dur_long) begin
				outcome_d = OUT_FAILED;
			end else begin
				shift_d = (shift_q << 1) | MAX_BITS'(on_long);
				bits_d  = bits_q + COUNT_W'(1);
				if (bits_d == cfg.bit_count) begin
					outcome_d = OUT_DONE;
				end
			end
		end
	end

	always_comb begin
		result.valid = take && last_of_capture;
		result.ok    = (outcome_d == OUT_DONE) && count_ok;
		result.code  = result.ok ? CODE_W'(shift_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_START;
			outcome_q <= OUT_RUNNING;
			held_q    <= '0;
			level_q   <= 1'b0;
			shift_q   <= '0;
			bits_q    <= '0;
		end else if (take) begin
			if (last_of_capture) begin
				pos_q     <= POS_START;
				outcome_q <= OUT_RUNNING;
				held_q    <= '0;
				level_q   <= 1'b0;
				shift_q   <= '0;
				bits_q    <= '0;
			end else begin
				pos_q     <= pos_d;
				outcome_q <= outcome_d;
				held_q    <= held_d;
				level_q   <= level_d;
				shift_q   <= shift_d;
				bits_q    <= bits_d;
			end
		end
	end

`include "ook_pulse_width_code_decoder_assert.svh"

	`OOKPW_ASSERT_NEXT(a_clear_after_last, take && last_of_capture,
		pos_q == POS_START && outcome_q == OUT_RUNNING && bits_q == '0,
		"capture state not cleared after last item")
	`OOKPW_ASSERT_SAME(a_bits_bounded, 1'b1, bits_q <= COUNT_W'(MAX_BITS),
		"bit counter beyond maximum")
	`OOKPW_ASSERT_SAME(a_done_has_bits, outcome_q == OUT_DONE, bits_q != '0,
		"frame done without any bit")

endmodule

/* rtl/ook_pulse_width_code_decoder.sv */
// top level of the on-off-keyed pulse width code decoder
`timescale 1ns / 1ps

// Decodes a captured remote frame given as pulse and gap durations.
// Input stream: one duration (us) per request in s_tdata, s_tuser carries the
// carrier level of the first item of a capture, s_tlast marks its final item.
// Output stream: one request per capture, on its last item; m_tdata holds the
// code (first bit most significant, zero on failure), m_tuser the ok flag.
// alpha_us (address 0) and bit_count (address 4) are set over the apb port.
// Throughput: one input item per cycle while no last item waits on a stalled
// output, set by the single decode stage that updates the frame state.
// Result path: a last item waits in the input register, its result is written
// to the output register once that is free, and m_tvalid comes from there.
// A stalled output holds its result; a new last item then waits in the input
// register and s_tready drops, while items that give no result keep flowing.
// Reset clears the capture state and the output valid and loads alpha_us 350
// and bit_count 24; no clearing pass is needed.
module ook_pulse_width_code_decoder import ookpw_pkg::*; #(
	parameter int MAX_BITS      = 32,
	parameter int DURATION_BITS = 24,
	localparam int IN_TDATA_W   = ((DURATION_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_W-1:0]      pwdata,
	output logic [APB_W-1:0]      prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // duration, zero padding
	input  logic                  s_tuser,  // first_level
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [CODE_W-1:0]     m_tdata,  // code
	output logic                  m_tuser   // ok
);

	cfg_t                     cfg;
	result_t                  result;

	logic                     valid_s1;
	logic [DURATION_BITS-1:0] dur_s1;
	logic                     level_s1;
	logic                     last_s1;
	logic                     s1_fire;
	logic                     out_free;

	logic                     m_valid_q;
	logic [CODE_W-1:0]        code_q;
	logic                     ok_q;

	ookpw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// only an item that makes a result needs room in the output register
	assign out_free = !m_valid_q || m_tready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dur_s1   <= s_tdata[DURATION_BITS-1:0];
			level_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	ookpw_core #(
		.MAX_BITS      (MAX_BITS),
		.DURATION_BITS (DURATION_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.take            (s1_fire),
		.duration        (dur_s1),
		.first_level     (level_s1),
		.last_of_capture (last_s1),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (result.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			code_q <= result.code;
			ok_q   <= result.ok;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = code_q;
	assign m_tuser  = ok_q;

`include "ook_pulse_width_code_decoder_assert.svh"

	`OOKPW_ASSERT_SAME(a_fail_zero_code, m_valid_q && !ok_q, code_q == '0,
		"failed frame with nonzero code")
	`OOKPW_ASSERT_SAME(a_no_overwrite, result.valid, out_free,
		"result written over a pending output")
	`OOKPW_ASSERT_NEXT(a_stage_holds, valid_s1 && !s1_fire,
		valid_s1 && $stable(dur_s1) && $stable(last_s1),
		"input stage lost a waiting item")

endmodule
